// ===== rtl/core/huffman_bit_packer_core_macros.svh =====
// Assertion helpers used by hbp_checker.sv.
`ifndef HUFFMAN_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_BIT_PACKER_CORE_MACROS_SVH

// Check a property on every rising edge, ignored while reset is asserted.
`define HBP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define HBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/hbp_pkg.sv =====
`timescale 1ns / 1ps
package hbp_pkg;

  // Code table geometry
  localparam int SYMBOL_COUNT    = 256;
  localparam int MAX_CODE_LENGTH = 24;
  localparam int IDX_W           = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 24;
  localparam int LEN_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 32;
  localparam int PEND_W  = 6;
  localparam int SHIFT_W = $clog2(ACC_W);
  localparam int ENTRY_W = CODE_W + LEN_W;

  // Pending-bit thresholds
  localparam logic [PEND_W-1:0] PEND_BYTE    = PEND_W'(BYTE_W);
  localparam logic [PEND_W-1:0] PEND_TWO     = PEND_W'(2 * BYTE_W);
  localparam logic [PEND_W-1:0] PEND_ACC     = PEND_W'(ACC_W);
  localparam logic [LEN_W-1:0]  LEN_MAX      = LEN_W'(MAX_CODE_LENGTH);

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } hbp_cmd_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hbp_entry_t;

  typedef struct packed {
    logic              is_flush;
    logic              unknown;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hbp_item_t;

  typedef struct packed {
    logic      valid;
    hbp_item_t item;
  } hbp_req_t;

endpackage

// ===== rtl/core/hbp_ram.sv =====
`timescale 1ns / 1ps
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hbp_queue.sv =====
`timescale 1ns / 1ps
module hbp_queue
  import hbp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  hbp_req_t push_i,
  output logic     full_o,
  output hbp_req_t head_o,
  input  logic     pop_i
);

  hbp_item_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.item;
    end
  end

endmodule

// ===== rtl/core/hbp_front.sv =====
`timescale 1ns / 1ps
module hbp_front
  import hbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [CODE_W-1:0] code_bits_i,
  input  logic [LEN_W-1:0]  code_length_i,
  output hbp_req_t          push_o,
  input  logic              full_i
);

  logic [SYMBOL_COUNT-1:0] vld_q, vld_d;
  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_flush_q, s1_flush_d;
  logic                    s1_unknown_q, s1_unknown_d;
  logic                    accept;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_W-1:0]       code_mask;
  logic                    ram_we;
  logic                    ram_re;
  hbp_entry_t              wr_entry;
  hbp_entry_t              rd_entry;

  // Hold input while the staged request cannot enter the queue
  assign in_stall_o = s1_valid_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_range = ({1'b0, symbol_i} < (SYM_W + 1)'(SYMBOL_COUNT));
  assign idx      = symbol_i[IDX_W-1:0];

  // Saturate length and mask code for a table load
  assign len_sat   = (code_length_i > LEN_MAX) ? LEN_MAX : code_length_i;
  assign code_mask = ~({CODE_W{1'b1}} << len_sat);
  assign wr_entry  = '{code: code_bits_i & code_mask, len: len_sat};

  // Classify the accepted request
  always_comb begin
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    vld_d        = vld_q;
    s1_valid_d   = s1_valid_q;
    s1_flush_d   = s1_flush_q;
    s1_unknown_d = s1_unknown_q;
    if (s1_valid_q && !full_i) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      case (hbp_cmd_e'(command_i))
        CMD_LOAD: begin
          if (in_range) begin
            ram_we     = 1'b1;
            vld_d[idx] = 1'b1;
          end
        end
        CMD_ENCODE: begin
          ram_re       = 1'b1;
          s1_valid_d   = 1'b1;
          s1_flush_d   = 1'b0;
          s1_unknown_d = !(in_range && vld_q[idx]);
        end
        CMD_FLUSH: begin
          s1_valid_d   = 1'b1;
          s1_flush_d   = 1'b1;
          s1_unknown_d = 1'b0;
        end
        default: begin
          // drop unused command
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      vld_q      <= vld_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_flush_q   <= s1_flush_d;
    s1_unknown_q <= s1_unknown_d;
  end

  // Code table
  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (rd_entry)
  );

  // Build queued request from staged flags and table data
  assign push_o.valid         = s1_valid_q;
  assign push_o.item.is_flush = s1_flush_q;
  assign push_o.item.unknown  = s1_unknown_q;
  assign push_o.item.code     = rd_entry.code;
  assign push_o.item.len      = rd_entry.len;

endmodule

// ===== rtl/core/hbp_back.sv =====
`timescale 1ns / 1ps
module hbp_back
  import hbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbp_req_t          head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o,
  output logic              unknown_symbol_o
);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic               ovld_q, ovld_d;
  logic [BYTE_W-1:0]  obyte_q, obyte_d;
  logic               olast_q, olast_d;
  logic               ounk_q, ounk_d;
  logic               slot_free;
  logic               draining;
  logic [PEND_W-1:0]  shamt;
  logic [ACC_W-1:0]   acc_app;
  logic [PEND_W-1:0]  pend_app;
  hbp_item_t          item;

  assign item      = head_i.item;
  assign slot_free = !ovld_q || !out_stall_i;
  assign draining  = (pend_q > PEND_BYTE);

  // Append the head code below the pending bits
  assign shamt    = PEND_ACC - pend_q - PEND_W'(item.len);
  assign pend_app = pend_q + PEND_W'(item.len);
  assign acc_app  = acc_q | (ACC_W'(item.code) << shamt[SHIFT_W-1:0]);

  always_comb begin
    acc_d   = acc_q;
    pend_d  = pend_q;
    pop_o   = 1'b0;
    ovld_d  = ovld_q && out_stall_i;
    obyte_d = obyte_q;
    olast_d = olast_q;
    ounk_d  = ounk_q;
    if (draining) begin
      // Emit the next full byte of the current code
      if (slot_free) begin
        ovld_d  = 1'b1;
        obyte_d = acc_q[ACC_W-1 -: BYTE_W];
        olast_d = (pend_q <= PEND_TWO);
        ounk_d  = 1'b0;
        acc_d   = acc_q << BYTE_W;
        pend_d  = pend_q - PEND_BYTE;
      end
    end else if (head_i.valid) begin
      if (item.is_flush) begin
        // Emit padded top byte and clear
        if (slot_free) begin
          pop_o   = 1'b1;
          ovld_d  = 1'b1;
          obyte_d = acc_q[ACC_W-1 -: BYTE_W];
          olast_d = 1'b1;
          ounk_d  = 1'b0;
          acc_d   = '0;
          pend_d  = '0;
        end
      end else if (item.unknown) begin
        if (slot_free) begin
          pop_o   = 1'b1;
          ovld_d  = 1'b1;
          obyte_d = '0;
          olast_d = 1'b1;
          ounk_d  = 1'b1;
        end
      end else if (item.len == '0) begin
        pop_o = 1'b1;
      end else if (pend_app <= PEND_BYTE) begin
        pop_o  = 1'b1;
        acc_d  = acc_app;
        pend_d = pend_app;
      end else if (slot_free) begin
        // Append and emit the first byte together
        pop_o   = 1'b1;
        ovld_d  = 1'b1;
        obyte_d = acc_app[ACC_W-1 -: BYTE_W];
        olast_d = (pend_app <= PEND_TWO);
        ounk_d  = 1'b0;
        acc_d   = acc_app << BYTE_W;
        pend_d  = pend_app - PEND_BYTE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    ounk_q  <= ounk_d;
  end

  assign out_valid_o      = ovld_q;
  assign out_byte_o       = obyte_q;
  assign last_o           = olast_q;
  assign unknown_symbol_o = ounk_q;

endmodule

// ===== rtl/core/huffman_bit_packer_core.sv =====
`timescale 1ns / 1ps
// A request's first byte passes the staged lookup, a queue slot and the output
// register. Throughput: one request per cycle while in_stall_o is low; an encode
// of up to 3 bytes holds the packer, one byte per cycle unless stalled.
// Reset: rst_ni clears the table valid marks, the accumulator and all control
// state at once; no clearing pass is needed.
module huffman_bit_packer_core
  import hbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [CODE_W-1:0] code_bits_i,
  input  logic [LEN_W-1:0]  code_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o,
  output logic              unknown_symbol_o
);

  hbp_req_t push;
  hbp_req_t head;
  logic     full;
  logic     pop;

  // Accept, look up and classify requests
  hbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .symbol_i      (symbol_i),
    .code_bits_i   (code_bits_i),
    .code_length_i (code_length_i),
    .push_o        (push),
    .full_i        (full)
  );

  // Decouple lookup from packing
  hbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Pack bits and emit bytes
  hbp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_o           (last_o),
    .unknown_symbol_o (unknown_symbol_o)
  );

endmodule

// ===== rtl/core/hbp_checker.sv =====
`timescale 1ns / 1ps
`include "huffman_bit_packer_core_macros.svh"
module hbp_checker
  import hbp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CMD_W-1:0]  command_i,
  input logic [SYM_W-1:0]  symbol_i,
  input logic [CODE_W-1:0] code_bits_i,
  input logic [LEN_W-1:0]  code_length_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [BYTE_W-1:0] out_byte_o,
  input logic              last_o,
  input logic              unknown_symbol_o
);

  // Stalled request holds
  `HBP_ASSERT(a_in_hold, clk_i, rst_ni,
    in_valid_i && in_stall_o |=> in_valid_i && $stable(command_i) && $stable(symbol_i)
      && $stable(code_bits_i) && $stable(code_length_i),
    "stalled request changed")

  // Stalled result holds
  `HBP_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o)
      && $stable(unknown_symbol_o),
    "stalled result changed")

  // Unknown symbol result is a single zero byte flagged last
  `HBP_ASSERT(a_unknown_shape, clk_i, rst_ni,
    out_valid_o && unknown_symbol_o |-> last_o && (out_byte_o == '0),
    "malformed unknown-symbol result")

  // No result and no input stall while in reset
  `HBP_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o, "activity during reset")

endmodule

bind huffman_bit_packer_core hbp_checker u_hbp_checker (.*);
